@@ hdl/rffp_pkg.sv @@
// Package for the RPC frame field parser: field kinds and frame constants.
package rffp_pkg;

  localparam int LEN_BITS_DEF = 32;
  localparam int HEADER_BYTES = 24;
  localparam int WORD_W       = 32;
  localparam int BYTE_W       = 8;
  localparam int OUT_TDATA_W  = 48;

  typedef enum logic [3:0] {
    FK_TOTAL_LEN  = 4'd0,
    FK_ID_LEN     = 4'd1,
    FK_ID         = 4'd2,
    FK_METHOD_LEN = 4'd3,
    FK_METHOD     = 4'd4,
    FK_ERR_CODE   = 4'd5,
    FK_ERR_LEN    = 4'd6,
    FK_ERR_TEXT   = 4'd7,
    FK_PAYLOAD    = 4'd8,
    FK_CHECKSUM   = 4'd9
  } field_kind_t;

endpackage

@@ hdl/rpc_frame_field_parser.sv @@
// RPC frame field parser: tags every byte of a length-prefixed frame stream.
//
// One byte word in, one tagged word out, at a sustained rate of one word per
// clock while out_tready stays high. A byte passes an input register, then
// combinational field decoding against the parse state, then the result
// register, which drives out_tvalid. The rate rests on the phase, the word
// shifter and the remaining-length counter updating per byte. Header words are
// big-endian 32-bit values; a negative or oversized string or payload length
// raises length_error on the fourth byte of the offending length word, and
// the next byte is parsed as the start of a new frame. Zero-length fields are
// skipped. The checksum is reported, not checked.
module rpc_frame_field_parser
  import rffp_pkg::*;
#(
  parameter int LEN_BITS = LEN_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [BYTE_W-1:0]      in_tdata,   // [7:0] in_byte
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] data_byte, [8] word_done,
                                             // [40:9] word_value, [41] field_last,
                                             // [42] length_error, [47:43] zero
  output logic [3:0]             out_tuser,  // [3:0] field_kind
  output logic                   out_tlast   // frame_last
);

  localparam int BL_W  = LEN_BITS - 1;
  localparam int SUM_W = LEN_BITS + 1;
  localparam int REM_W = ((SUM_W > WORD_W) ? SUM_W : WORD_W) + 2;

  // input stage
  logic              in_v_r;
  logic [BYTE_W-1:0] in_b_r;
  logic              adv;

  // parse state
  field_kind_t               phase_r, phase_nxt;
  logic [1:0]                biw_r, biw_nxt;
  logic [23:0]               shift_r, shift_nxt;
  logic [BL_W-1:0]           left_r, left_nxt;
  logic signed [REM_W-1:0]   rem_r, rem_nxt;

  // decode
  logic                    is_word, word_last, byte_last, w_ok, pl_ok;
  logic                    flast, frlast, err;
  logic [WORD_W-1:0]       word;
  logic signed [REM_W-1:0] word_z, word_s, pl;

  // result register
  logic                   out_v_r;
  logic [OUT_TDATA_W-1:0] out_d_r;
  logic [3:0]             out_k_r;
  logic                   out_l_r;

  assign adv       = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_b_r <= in_tdata;
    end
  end

  assign word   = {shift_r, in_b_r};
  assign word_z = REM_W'({{(REM_W-WORD_W){1'b0}}, word});
  assign word_s = REM_W'({{(REM_W-WORD_W){word[WORD_W-1]}}, word});
  assign pl     = rem_r - word_z;
  assign w_ok   = (word[WORD_W-1:LEN_BITS-1] == '0);
  assign pl_ok  = (pl[REM_W-1:LEN_BITS-1] == '0);

  // output decode
  always_comb begin
    case (phase_r)
      FK_TOTAL_LEN, FK_ID_LEN, FK_METHOD_LEN, FK_ERR_CODE, FK_ERR_LEN,
      FK_CHECKSUM: is_word = 1'b1;
      default:     is_word = 1'b0;
    endcase
    word_last = is_word && (biw_r == 2'd3);
    byte_last = !is_word && (left_r <= BL_W'(1));
    flast     = word_last || byte_last;
    frlast    = word_last && (phase_r == FK_CHECKSUM);
    err       = 1'b0;
    if (word_last) begin
      if ((phase_r == FK_ID_LEN || phase_r == FK_METHOD_LEN ||
           phase_r == FK_ERR_LEN) && !w_ok) begin
        err = 1'b1;
      end
      if (phase_r == FK_ERR_LEN && !pl_ok) begin
        err = 1'b1;
      end
    end
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    biw_nxt   = biw_r;
    shift_nxt = shift_r;
    left_nxt  = left_r;
    rem_nxt   = rem_r;
    if (is_word) begin
      if (!word_last) begin
        shift_nxt = {shift_r[15:0], in_b_r};
        biw_nxt   = biw_r + 2'd1;
      end else begin
        shift_nxt = '0;
        biw_nxt   = 2'd0;
        unique case (phase_r)
          FK_TOTAL_LEN: begin
            rem_nxt   = word_s - REM_W'(HEADER_BYTES);
            phase_nxt = FK_ID_LEN;
          end
          FK_ID_LEN, FK_METHOD_LEN: begin
            rem_nxt  = rem_r - word_z;
            left_nxt = word[BL_W-1:0];
            if (word != '0) begin
              phase_nxt = (phase_r == FK_ID_LEN) ? FK_ID : FK_METHOD;
            end else begin
              phase_nxt = (phase_r == FK_ID_LEN) ? FK_METHOD_LEN : FK_ERR_CODE;
            end
          end
          FK_ERR_CODE: phase_nxt = FK_ERR_LEN;
          FK_ERR_LEN: begin
            rem_nxt = pl;
            if (word != '0) begin
              left_nxt  = word[BL_W-1:0];
              phase_nxt = FK_ERR_TEXT;
            end else if (pl != '0) begin
              left_nxt  = pl[BL_W-1:0];
              phase_nxt = FK_PAYLOAD;
            end else begin
              left_nxt  = '0;
              phase_nxt = FK_CHECKSUM;
            end
          end
          default: phase_nxt = FK_TOTAL_LEN;
        endcase
        if (err) begin
          phase_nxt = FK_TOTAL_LEN;
          left_nxt  = '0;
          rem_nxt   = '0;
        end
      end
    end else begin
      if (left_r != '0) begin
        left_nxt = left_r - BL_W'(1);
      end
      if (byte_last) begin
        left_nxt = '0;
        unique case (phase_r)
          FK_ID:     phase_nxt = FK_METHOD_LEN;
          FK_METHOD: phase_nxt = FK_ERR_CODE;
          FK_ERR_TEXT: begin
            if (rem_r != '0) begin
              left_nxt  = rem_r[BL_W-1:0];
              phase_nxt = FK_PAYLOAD;
            end else begin
              phase_nxt = FK_CHECKSUM;
            end
          end
          default:   phase_nxt = FK_CHECKSUM;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= FK_TOTAL_LEN;
      biw_r   <= 2'd0;
      shift_r <= '0;
      left_r  <= '0;
      rem_r   <= '0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      biw_r   <= biw_nxt;
      shift_r <= shift_nxt;
      left_r  <= left_nxt;
      rem_r   <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_d_r <= {5'd0, err, flast, (word_last ? word : {WORD_W{1'b0}}),
                  word_last, in_b_r};
      out_k_r <= phase_r;
      out_l_r <= frlast;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;
  assign out_tuser  = out_k_r;
  assign out_tlast  = out_l_r;

  a_err_is_len_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[42]) |-> (out_tdata[8] && out_tdata[41] && !out_tlast &&
      (out_tuser == FK_ID_LEN || out_tuser == FK_METHOD_LEN || out_tuser == FK_ERR_LEN)))
    else $error("length error outside a length word");

  a_frame_last_checksum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tuser == FK_CHECKSUM && out_tdata[8]))
    else $error("frame end not on checksum word");

  a_word_done_field_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[8]) |-> out_tdata[41])
    else $error("word completed without field end");

  a_restart_after_err: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && err) |=> (phase_r == FK_TOTAL_LEN && biw_r == 2'd0))
    else $error("parser did not restart after length error");

  a_byte_field_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !is_word) |-> (left_r != '0))
    else $error("byte field entered with zero length");

endmodule
